// ===== hdl/hkrt_pkg.sv =====
package hkrt_pkg;

   // Number of key slots that the report keeps.
   localparam int KEY_SLOTS = 16;
   // At most this many slots are reported after each command.
   localparam int REPORT_MAX = 16;
   localparam int REPORT_N = (KEY_SLOTS < REPORT_MAX) ? KEY_SLOTS : REPORT_MAX;

   localparam int SLOT_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int REPORT_IDX_W = (REPORT_N > 1) ? $clog2(REPORT_N) : 1;
   localparam int COUNT_W = $clog2(KEY_SLOTS + 1);

   // Modifier usage codes 0xE0 to 0xE7.
   localparam logic [7:0] MOD_GROUP_MASK = 8'hf8;
   localparam logic [7:0] MOD_GROUP_CODE = 8'he0;
   localparam logic [7:0] MOD_BIT_MASK = 8'h07;

   // Command codes.
   localparam logic [1:0] MODE_DOWN = 2'd0;
   localparam logic [1:0] MODE_UP = 2'd1;
   localparam logic [1:0] MODE_NOOP = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [3:0] slot_index;
      logic [7:0] slot_key;
      logic [7:0] modifiers;
      logic [4:0] key_count;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic apply;
      logic first;
      logic advance;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_slot;
   } ctl_sts_type;

endpackage

// ===== hdl/hid_key_report_tracker.sv =====
// Keyboard HID report tracker. Each request transaction carries one command
// (key down, key up, no-op or clear) and a usage code; codes 0xE0 to 0xE7 set or
// clear modifier bits, other nonzero codes are added to or removed from an ordered
// list of 16 key slots. After every command the full report is returned as 16
// response transactions, slot 0 first, each carrying the slot's code, the modifier
// mask and the key count, with last set on slot 15. A command is accepted, then
// the slot registers are updated, then the slots are reported one at a time,
// paced by the slot counter and held while the response side stalls. A new request
// is taken only once the previous report has been fully delivered.
module hid_key_report_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hkrt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hkrt_pkg::rsp_type rsp_payload
);

   hkrt_pkg::ctl_cmd_type cmd;
   hkrt_pkg::ctl_sts_type sts;

   // Command sequencing.
   hkrt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Report state and slot readout.
   hkrt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/hkrt_datapath.sv =====
module hkrt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  hkrt_pkg::req_type     req_payload,
   input  hkrt_pkg::ctl_cmd_type cmd,
   output hkrt_pkg::ctl_sts_type sts,
   output hkrt_pkg::rsp_type     rsp_payload
);

   logic [7:0] slots_ff [hkrt_pkg::KEY_SLOTS];
   logic [7:0] slots_in [hkrt_pkg::KEY_SLOTS];
   logic [7:0] mod_ff;
   logic [7:0] mod_in;
   logic [hkrt_pkg::COUNT_W-1:0] count_ff;
   logic [hkrt_pkg::COUNT_W-1:0] count_in;
   logic [hkrt_pkg::REPORT_IDX_W-1:0] idx_ff;
   logic [hkrt_pkg::REPORT_IDX_W-1:0] idx_in;
   hkrt_pkg::req_type cmd_ff;
   hkrt_pkg::req_type cmd_in;

   logic [hkrt_pkg::KEY_SLOTS-1:0] match;
   logic [hkrt_pkg::KEY_SLOTS-1:0] at_or_after;
   logic [7:0] shifted [hkrt_pkg::KEY_SLOTS];
   logic       is_mod;
   logic       code_nz;
   logic       any_match;
   logic       full;
   logic [7:0] mod_bit;
   logic       seen;
   logic [hkrt_pkg::SLOT_IDX_W-1:0] slot_sel;

   // Decode of the held command.
   always_comb begin
      is_mod = (cmd_ff.key_code & hkrt_pkg::MOD_GROUP_MASK) == hkrt_pkg::MOD_GROUP_CODE;
      code_nz = cmd_ff.key_code != 8'h00;
      mod_bit = 8'h01 << (cmd_ff.key_code & hkrt_pkg::MOD_BIT_MASK);
      full = count_ff == hkrt_pkg::COUNT_W'(hkrt_pkg::KEY_SLOTS);
   end

   // Compare the code against every slot. Empty slots hold zero and a zero code
   // is never looked up, so only occupied slots can match.
   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
         match[i] = slots_ff[i] == cmd_ff.key_code;
         seen = seen | match[i];
         at_or_after[i] = seen;
      end
      any_match = seen;
   end

   // Slots moved down by one for a key release.
   always_comb begin
      for (int i = 0; i < hkrt_pkg::KEY_SLOTS - 1; i++) begin
         shifted[i] = slots_ff[i + 1];
      end
      shifted[hkrt_pkg::KEY_SLOTS - 1] = 8'h00;
   end

   // Next report state for the held command.
   always_comb begin
      slots_in = slots_ff;
      mod_in = mod_ff;
      count_in = count_ff;
      if (cmd.apply) begin
         unique case (cmd_ff.mode)
            hkrt_pkg::MODE_DOWN: begin
               if (is_mod) begin
                  mod_in = mod_ff | mod_bit;
               end else if (code_nz && !any_match && !full) begin
                  for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
                     if (count_ff == hkrt_pkg::COUNT_W'(i)) begin
                        slots_in[i] = cmd_ff.key_code;
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            hkrt_pkg::MODE_UP: begin
               if (is_mod) begin
                  mod_in = mod_ff & ~mod_bit;
               end else if (code_nz && any_match) begin
                  for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
                     if (at_or_after[i]) begin
                        slots_in[i] = shifted[i];
                     end
                  end
                  count_in = count_ff - 1'b1;
               end
            end
            hkrt_pkg::MODE_CLEAR: begin
               for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
                  slots_in[i] = 8'h00;
               end
               mod_in = 8'h00;
               count_in = '0;
            end
            hkrt_pkg::MODE_NOOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Held command capture and report slot counter.
   always_comb begin
      cmd_in = cmd.capture ? req_payload : cmd_ff;
      if (cmd.first) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hkrt_pkg::KEY_SLOTS; i++) begin
            slots_ff[i] <= 8'h00;
         end
         mod_ff <= 8'h00;
         count_ff <= '0;
      end else begin
         slots_ff <= slots_in;
         mod_ff <= mod_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

   // Result fields for the slot being reported.
   always_comb begin
      slot_sel = hkrt_pkg::SLOT_IDX_W'(idx_ff);
      sts.last_slot = idx_ff == hkrt_pkg::REPORT_IDX_W'(hkrt_pkg::REPORT_N - 1);
      rsp_payload.slot_index = 4'(idx_ff);
      rsp_payload.slot_key = slots_ff[slot_sel];
      rsp_payload.modifiers = mod_ff;
      rsp_payload.key_count = 5'(count_ff);
      rsp_payload.last = sts.last_slot;
   end

endmodule

// ===== hdl/hkrt_controller.sv =====
module hkrt_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  hkrt_pkg::ctl_sts_type  sts,
   output hkrt_pkg::ctl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_APPLY = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence: take one transaction, update the report, then emit every slot.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            cmd.first = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.advance = 1'b1;
               if (sts.last_slot) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
